// ===== src/mbg_pkg.sv =====
// Shared types and codes for the maze backtracker generator.
// Used by the neighbor pick logic and the top level; depends on nothing.
package mbg_pkg;

    // Result kinds reported with each transaction on the output channel.
    typedef enum logic [1:0] {
        KIND_CARVE = 2'd0,
        KIND_BACK  = 2'd1,
        KIND_FIN   = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    // Carve directions, in probe order.
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // Input actions.
    localparam logic ACT_STEP = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Configuration register indexes and reset value.
    localparam logic       CFG_MAZE_WIDTH  = 1'b0;
    localparam logic       CFG_MAZE_HEIGHT = 1'b1;
    localparam logic [5:0] SIZE_RESET      = 6'd21;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_PROBE   = 8'b0000_0100,
        ST_SELECT  = 8'b0000_1000,
        ST_CARVE_A = 8'b0001_0000,
        ST_CARVE_B = 8'b0010_0000,
        ST_POP     = 8'b0100_0000,
        ST_REPORT  = 8'b1000_0000
    } state_t;

    // Outcome of the neighbor pick.
    typedef struct packed {
        logic       found;
        logic [1:0] dir;
    } pick_t;

endpackage

// ===== src/mbg_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Holds the cell store and the path stack; no dependencies.
module mbg_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/mbg_pick.sv =====
// Neighbor pick: reduces the random word by the candidate count and selects
// that candidate from the open-neighbor mask. Depends on mbg_pkg.
module mbg_pick import mbg_pkg::*; (
    input  logic [3:0]  cand,
    input  logic [15:0] rand_word,
    output pick_t       pick
);

    // Remainder by three: base-4 digits add up modulo three.
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 4'(s[4:2]) + 4'(s[1:0]);
        u = 3'(t[3:2]) + 3'(t[1:0]);
        if (u >= 3'd3)
        begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

    logic [2:0] count;
    logic [1:0] idx;
    logic [2:0] seen;

    // Candidate count and the index chosen by the random word.
    always_comb
    begin
        count = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
        case (count)
            3'd2:    idx = {1'b0, rand_word[0]};
            3'd3:    idx = mod3_16(rand_word);
            3'd4:    idx = rand_word[1:0];
            default: idx = 2'd0;
        endcase
    end

    // Walk the mask in N, E, S, W order to the chosen candidate.
    always_comb
    begin
        seen = '0;
        pick = '{found: 1'b0, dir: DIR_N};
        for (int d = 0; d < 4; d++)
        begin
            if (cand[d] && !pick.found && seen == {1'b0, idx})
            begin
                pick.found = 1'b1;
                pick.dir   = 2'(d);
            end
            if (cand[d])
            begin
                seen = seen + 3'd1;
            end
        end
    end

endmodule

// ===== src/maze_backtracker_generator.sv =====
// Top level of the maze backtracker generator: sequencer, registers and stores.
// Depends on mbg_pkg, mbg_ram and mbg_pick.
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   config   | cfg_write_en, cfg_index, cfg_data              | in
//   input    | in_valid/in_ready, action, random_word,        | in
//            | read_col, read_row                             |
//   output   | out_valid/out_ready, kind, cell_col, cell_row, | out
//            | direction, wall_bits                           |
//
// A step reads the four neighbors through the cell store read port (PROBE), then
// picks one (SELECT) and carves it (CARVE_A, CARVE_B), pops the stack (POP,
// REPORT) or, when it finishes, reports (REPORT). A wall read goes to REPORT.
// After reset a clearing pass writes all MAX_ROWS * 2**clog2(MAX_COLS) entries
// (1024 by default) of the cell store; no input is accepted meanwhile.
// A waiting result does not block acceptance; only the final state of an
// item (CARVE_B or REPORT) waits for the output register to free up.
module maze_backtracker_generator import mbg_pkg::*; #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [15:0] random_word,
    input  logic [4:0]  read_col,
    input  logic [4:0]  read_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [4:0]  cell_col,
    output logic [4:0]  cell_row,
    output logic [1:0]  direction,
    output logic [3:0]  wall_bits
);

    localparam int CW        = $clog2(MAX_COLS);
    localparam int RW        = $clog2(MAX_ROWS);
    localparam int AW        = CW + RW;
    localparam int MEM_DEPTH = MAX_ROWS * (2 ** CW);
    localparam int SDEPTH    = MAX_COLS * MAX_ROWS;
    localparam int SAW       = $clog2(SDEPTH);

    // Control registers.
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [5:0]      maze_width_reg, maze_width_next;
    logic [5:0]      maze_height_reg, maze_height_next;
    logic            started_reg, started_next;
    logic [CW-1:0]   here_col_reg, here_col_next;
    logic [RW-1:0]   here_row_reg, here_row_next;
    logic [SAW:0]    depth_reg, depth_next;
    logic [2:0]      probe_reg, probe_next;
    logic [3:0]      cand_reg, cand_next;
    logic            out_valid_reg, out_valid_next;

    // Payload registers.
    logic [15:0]     rand_reg, rand_next;
    logic [1:0]      dir_reg, dir_next;
    logic [CW-1:0]   new_col_reg, new_col_next;
    logic [RW-1:0]   new_row_reg, new_row_next;
    kind_t           rep_kind_reg, rep_kind_next;
    logic [4:0]      rep_col_reg, rep_col_next;
    logic [4:0]      rep_row_reg, rep_row_next;
    logic            rep_oob_reg, rep_oob_next;
    kind_t           out_kind_reg, out_kind_next;
    logic [4:0]      out_col_reg, out_col_next;
    logic [4:0]      out_row_reg, out_row_next;
    logic [1:0]      out_dir_reg, out_dir_next;
    logic [3:0]      out_walls_reg, out_walls_next;

    // Store ports.
    logic            cell_we, cell_re;
    logic [AW-1:0]   cell_waddr, cell_raddr;
    logic [4:0]      cell_wdata, cell_rdata;
    logic            stk_we, stk_re;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [AW-1:0]   stk_wdata, stk_rdata;

    // Derived values.
    logic [CW:0]     w_eff;
    logic [CW:0]     x_ext;
    logic [RW:0]     y_ext;
    logic [RW:0]     h_cmp;
    logic            in_area;
    logic [3:0]      nvalid;
    logic [CW-1:0]   nb_col [4];
    logic [RW-1:0]   nb_row [4];
    logic [1:0]      probe_dir;
    logic            out_free;
    logic            read_oob;
    pick_t           pick;

    mbg_ram #(.DEPTH(MEM_DEPTH), .AW(AW), .DW(5)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    mbg_ram #(.DEPTH(SDEPTH), .AW(SAW), .DW(AW)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    mbg_pick u_pick (
        .cand      (cand_reg),
        .rand_word (rand_reg),
        .pick      (pick)
    );

    // Effective maze size: zero acts as one, large values saturate.
    always_comb
    begin
        if (maze_width_reg == 6'd0)
        begin
            w_eff = (CW+1)'(1);
        end
        else if (int'(maze_width_reg) > MAX_COLS)
        begin
            w_eff = (CW+1)'(MAX_COLS);
        end
        else
        begin
            w_eff = (CW+1)'(maze_width_reg);
        end
        if (maze_height_reg == 6'd0)
        begin
            h_cmp = (RW+1)'(1);
        end
        else if (int'(maze_height_reg) > MAX_ROWS)
        begin
            h_cmp = (RW+1)'(MAX_ROWS);
        end
        else
        begin
            h_cmp = (RW+1)'(maze_height_reg);
        end
    end

    // Neighbor legality and coordinates around the current cell.
    always_comb
    begin
        x_ext     = {1'b0, here_col_reg};
        y_ext     = {1'b0, here_row_reg};
        in_area   = (x_ext < w_eff) && (y_ext < h_cmp);
        nvalid[0] = in_area && (here_row_reg != '0);
        nvalid[1] = in_area && ((x_ext + (CW+1)'(1)) < w_eff);
        nvalid[2] = in_area && ((y_ext + (RW+1)'(1)) < h_cmp);
        nvalid[3] = in_area && (here_col_reg != '0);
        nb_col[DIR_N] = here_col_reg;
        nb_row[DIR_N] = here_row_reg - RW'(1);
        nb_col[DIR_E] = here_col_reg + CW'(1);
        nb_row[DIR_E] = here_row_reg;
        nb_col[DIR_S] = here_col_reg;
        nb_row[DIR_S] = here_row_reg + RW'(1);
        nb_col[DIR_W] = here_col_reg - CW'(1);
        nb_row[DIR_W] = here_row_reg;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign probe_dir = 2'(probe_reg - 3'd1);
    assign read_oob  = (int'(read_col) >= MAX_COLS) || (int'(read_row) >= MAX_ROWS);

    // Sequencer and store access.
    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        maze_width_next  = maze_width_reg;
        maze_height_next = maze_height_reg;
        started_next     = started_reg;
        here_col_next    = here_col_reg;
        here_row_next    = here_row_reg;
        depth_next       = depth_reg;
        probe_next       = probe_reg;
        cand_next        = cand_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        rand_next        = rand_reg;
        dir_next         = dir_reg;
        new_col_next     = new_col_reg;
        new_row_next     = new_row_reg;
        rep_kind_next    = rep_kind_reg;
        rep_col_next     = rep_col_reg;
        rep_row_next     = rep_row_reg;
        rep_oob_next     = rep_oob_reg;
        out_kind_next    = out_kind_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        out_dir_next     = out_dir_reg;
        out_walls_next   = out_walls_reg;
        cell_we          = 1'b0;
        cell_waddr       = {here_row_reg, here_col_reg};
        cell_wdata       = 5'b0_1111;
        cell_re          = 1'b0;
        cell_raddr       = {here_row_reg, here_col_reg};
        stk_we           = 1'b0;
        stk_waddr        = depth_reg[SAW-1:0];
        stk_wdata        = {here_row_reg, here_col_reg};
        stk_re           = 1'b0;
        stk_raddr        = SAW'(depth_reg - (SAW+1)'(1));

        // Configuration writes.
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MAZE_WIDTH:  maze_width_next  = cfg_data;
                CFG_MAZE_HEIGHT: maze_height_next = cfg_data;
                default:         maze_width_next  = maze_width_reg;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                cell_we       = 1'b1;
                cell_waddr    = clr_addr_reg;
                cell_wdata    = 5'b0_1111;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rand_next = random_word;
                    if (action == ACT_READ)
                    begin
                        cell_re       = !read_oob;
                        cell_raddr    = {RW'(read_row), CW'(read_col)};
                        rep_kind_next = KIND_READ;
                        rep_col_next  = read_col;
                        rep_row_next  = read_row;
                        rep_oob_next  = read_oob;
                        state_next    = ST_REPORT;
                    end
                    else
                    begin
                        // The first step marks the start cell visited.
                        if (!started_reg)
                        begin
                            started_next = 1'b1;
                            cell_we      = 1'b1;
                            cell_wdata   = 5'b1_1111;
                        end
                        probe_next = 3'd0;
                        cand_next  = '0;
                        state_next = ST_PROBE;
                    end
                end
            end

            ST_PROBE:
            begin
                // Capture the previous neighbor, then issue the next read.
                if (probe_reg != 3'd0)
                begin
                    cand_next[probe_dir] = nvalid[probe_dir] && !cell_rdata[4];
                end
                if (probe_reg == 3'd4)
                begin
                    state_next = ST_SELECT;
                end
                else
                begin
                    cell_re    = 1'b1;
                    cell_raddr = {nb_row[probe_reg[1:0]], nb_col[probe_reg[1:0]]};
                    probe_next = probe_reg + 3'd1;
                end
            end

            ST_SELECT:
            begin
                if (pick.found)
                begin
                    dir_next     = pick.dir;
                    new_col_next = nb_col[pick.dir];
                    new_row_next = nb_row[pick.dir];
                    if (depth_reg < (SAW+1)'(SDEPTH))
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + (SAW+1)'(1);
                    end
                    cell_re    = 1'b1;
                    state_next = ST_CARVE_A;
                end
                else if (depth_reg != '0)
                begin
                    stk_re     = 1'b1;
                    depth_next = depth_reg - (SAW+1)'(1);
                    state_next = ST_POP;
                end
                else
                begin
                    cell_re       = 1'b1;
                    rep_kind_next = KIND_FIN;
                    rep_col_next  = 5'(here_col_reg);
                    rep_row_next  = 5'(here_row_reg);
                    rep_oob_next  = 1'b0;
                    state_next    = ST_REPORT;
                end
            end

            ST_CARVE_A:
            begin
                // Open the wall on the old cell, fetch the new one.
                cell_we    = 1'b1;
                cell_wdata = {cell_rdata[4], cell_rdata[3:0] & ~(4'd1 << dir_reg)};
                cell_re    = 1'b1;
                cell_raddr = {new_row_reg, new_col_reg};
                state_next = ST_CARVE_B;
            end

            ST_CARVE_B:
            begin
                if (out_free)
                begin
                    cell_we        = 1'b1;
                    cell_waddr     = {new_row_reg, new_col_reg};
                    cell_wdata     = {1'b1,
                                      cell_rdata[3:0] & ~(4'd1 << (dir_reg + 2'd2))};
                    here_col_next  = new_col_reg;
                    here_row_next  = new_row_reg;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CARVE;
                    out_col_next   = 5'(new_col_reg);
                    out_row_next   = 5'(new_row_reg);
                    out_dir_next   = dir_reg;
                    out_walls_next = cell_rdata[3:0] & ~(4'd1 << (dir_reg + 2'd2));
                    state_next     = ST_IDLE;
                end
            end

            ST_POP:
            begin
                here_col_next = stk_rdata[CW-1:0];
                here_row_next = stk_rdata[AW-1:CW];
                cell_re       = 1'b1;
                cell_raddr    = stk_rdata;
                rep_kind_next = KIND_BACK;
                rep_col_next  = 5'(stk_rdata[CW-1:0]);
                rep_row_next  = 5'(stk_rdata[AW-1:CW]);
                rep_oob_next  = 1'b0;
                state_next    = ST_REPORT;
            end

            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = rep_kind_reg;
                    out_col_next   = rep_col_reg;
                    out_row_next   = rep_row_reg;
                    out_dir_next   = DIR_N;
                    out_walls_next = rep_oob_reg ? 4'd0 : cell_rdata[3:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            maze_width_reg  <= SIZE_RESET;
            maze_height_reg <= SIZE_RESET;
            started_reg     <= 1'b0;
            here_col_reg    <= '0;
            here_row_reg    <= '0;
            depth_reg       <= '0;
            probe_reg       <= '0;
            cand_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            maze_width_reg  <= maze_width_next;
            maze_height_reg <= maze_height_next;
            started_reg     <= started_next;
            here_col_reg    <= here_col_next;
            here_row_reg    <= here_row_next;
            depth_reg       <= depth_next;
            probe_reg       <= probe_next;
            cand_reg        <= cand_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rand_reg      <= rand_next;
        dir_reg       <= dir_next;
        new_col_reg   <= new_col_next;
        new_row_reg   <= new_row_next;
        rep_kind_reg  <= rep_kind_next;
        rep_col_reg   <= rep_col_next;
        rep_row_reg   <= rep_row_next;
        rep_oob_reg   <= rep_oob_next;
        out_kind_reg  <= out_kind_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_dir_reg   <= out_dir_next;
        out_walls_reg <= out_walls_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign cell_col  = out_col_reg;
    assign cell_row  = out_row_reg;
    assign direction = out_dir_reg;
    assign wall_bits = out_walls_reg;

    // A carve that completes always leaves a carve result in the output register.
    a_carve_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CARVE_B && out_free) |=> (out_valid_reg && out_kind_reg == KIND_CARVE))
        else $error("carve did not produce a carve result");

    // With no candidate and an empty stack the step goes straight to a report.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SELECT && !pick.found && depth_reg == '0)
        |=> (state_reg == ST_REPORT && depth_reg == '0))
        else $error("stack popped while empty");

    // The cell store never reads the entry it writes in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_we && cell_re) |-> (cell_waddr != cell_raddr))
        else $error("cell store read and write hit the same entry");

    // The current cell always lies inside the stores.
    a_here_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(here_row_reg) < MAX_ROWS) && (int'(here_col_reg) < MAX_COLS))
        else $error("current cell outside the stores");

    // The sequencer stays one-hot.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule
